### rtl/xxh_pkg.sv
// Package: xxHash32 constants, queue entry type and helper functions.
`default_nettype none
package xxh_pkg;
   localparam logic [31:0] PRIME1 = 32'd2654435761;
   localparam logic [31:0] PRIME2 = 32'd2246822519;
   localparam logic [31:0] PRIME3 = 32'd3266489917;
   localparam logic [31:0] PRIME4 = 32'd668265263;
   localparam logic [31:0] PRIME5 = 32'd374761393;

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        last;
   } entry_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
      rotl32 = (x << r) | (x >> (32 - r));
   endfunction
endpackage
`default_nettype wire

### rtl/xxh_if.sv
// Interfaces: valid/ready request channel and response channel.
`default_nettype none
interface xxh_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   logic [2:0]  valid_bytes;
   logic        last;
   modport source (output valid, data, valid_bytes, last, input ready);
   modport sink (input valid, data, valid_bytes, last, output ready);
endinterface

interface xxh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash;
   modport source (output valid, hash, input ready);
   modport sink (input valid, hash, output ready);
endinterface
`default_nettype wire

### rtl/xxh_front.sv
// Front end: accept requests, normalize byte count, push into a two-entry queue.
`default_nettype none
module xxh_front (
   input  wire logic            clock,
   input  wire logic            reset,
   xxh_req_if.sink              req,
   output xxh_pkg::entry_type   q_data,
   output logic                 q_valid,
   input  wire logic            q_pop
);
   xxh_pkg::entry_type mem_ff [2];
   xxh_pkg::entry_type mem_in;
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = mem_ff[rp_ff];

   always_comb begin
      mem_in.data   = req.data;
      mem_in.last   = req.last;
      if (!req.last || req.valid_bytes > 3'd4) begin
         mem_in.nbytes = 3'd4;
      end else begin
         mem_in.nbytes = req.valid_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= mem_in;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (q_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end
endmodule
`default_nettype wire

### rtl/xxh_back.sv
// Back end: stripe absorption, finish sequence and avalanche with one shared multiplier.
`default_nettype none
module xxh_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire xxh_pkg::entry_type  q_data,
   input  wire logic                q_valid,
   output logic                     q_pop,
   xxh_rsp_if.source                rsp
);
   typedef enum logic [3:0] {
      S_IDLE, S_RND_MUL1, S_RND_MUL2, S_MERGE, S_W_MUL1, S_W_MUL2,
      S_B_MUL1, S_B_MUL2, S_AV1, S_AV2, S_AV3
   } state_type;

   state_type   state_ff;
   logic [31:0] acc_ff [4];
   logic [31:0] pend_ff [3];
   logic [1:0]  pcnt_ff;
   logic [31:0] total_ff;
   logic        seen_ff;
   logic [31:0] h_ff;
   logic [1:0]  idx_ff;
   logic [1:0]  lane_ff;
   logic [2:0]  nb_ff;
   logic [31:0] data_ff;
   logic [31:0] tmp_ff;
   logic [31:0] hash_ff;
   logic        rv_ff;
   logic        last_q_ff;
   logic [31:0] mul_a, mul_b, prod;
   logic [31:0] lane_w;

   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign rsp.valid = rv_ff;
   assign rsp.hash  = hash_ff;
   assign prod      = mul_a * mul_b;
   assign lane_w    = (lane_ff == 2'd3) ? data_ff : pend_ff[lane_ff];

   always_comb begin
      mul_a = tmp_ff;
      mul_b = xxh_pkg::PRIME1;
      case (state_ff)
         S_RND_MUL1: begin mul_a = lane_w;                 mul_b = xxh_pkg::PRIME2; end
         S_RND_MUL2: begin mul_a = tmp_ff;                 mul_b = xxh_pkg::PRIME1; end
         S_W_MUL1:   begin mul_a = pend_ff[idx_ff];        mul_b = xxh_pkg::PRIME3; end
         S_W_MUL2:   begin mul_a = tmp_ff;                 mul_b = xxh_pkg::PRIME4; end
         S_B_MUL1:   begin mul_a = {24'd0, data_ff[7:0]};  mul_b = xxh_pkg::PRIME5; end
         S_B_MUL2:   begin mul_a = tmp_ff;                 mul_b = xxh_pkg::PRIME1; end
         S_AV1:      begin mul_a = h_ff ^ (h_ff >> 15);    mul_b = xxh_pkg::PRIME2; end
         S_AV2:      begin mul_a = h_ff ^ (h_ff >> 13);    mul_b = xxh_pkg::PRIME3; end
         default:    begin mul_a = tmp_ff;                 mul_b = xxh_pkg::PRIME1; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         acc_ff[0] <= xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
         acc_ff[1] <= xxh_pkg::PRIME2;
         acc_ff[2] <= 32'd0;
         acc_ff[3] <= 32'd0 - xxh_pkg::PRIME1;
         pcnt_ff   <= 2'd0;
         total_ff  <= 32'd0;
         seen_ff   <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         if (rv_ff && rsp.ready && state_ff != S_AV3) rv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  total_ff <= total_ff + {29'd0, q_data.nbytes};
                  data_ff  <= q_data.data;
                  nb_ff    <= q_data.nbytes;
                  idx_ff   <= 2'd0;
                  lane_ff  <= 2'd0;
                  if (q_data.nbytes == 3'd4 && pcnt_ff != 2'd3) begin
                     pend_ff[pcnt_ff] <= q_data.data;
                     pcnt_ff <= pcnt_ff + 2'd1;
                     state_ff <= q_data.last ? S_MERGE : S_IDLE;
                  end else if (q_data.nbytes == 3'd4) begin
                     state_ff <= S_RND_MUL1;
                  end else begin
                     state_ff <= S_MERGE;
                  end
               end
            end
            S_RND_MUL1: begin
               tmp_ff   <= xxh_pkg::rotl32(acc_ff[lane_ff] + prod, 13);
               state_ff <= S_RND_MUL2;
            end
            S_RND_MUL2: begin
               acc_ff[lane_ff] <= prod;
               lane_ff <= lane_ff + 2'd1;
               if (lane_ff == 2'd3) begin
                  pcnt_ff  <= 2'd0;
                  seen_ff  <= 1'b1;
                  nb_ff    <= 3'd0;
                  state_ff <= last_q_ff ? S_MERGE : S_IDLE;
               end else begin
                  state_ff <= S_RND_MUL1;
               end
            end
            S_MERGE: begin
               h_ff <= (seen_ff ? (xxh_pkg::rotl32(acc_ff[0], 1) +
                                   xxh_pkg::rotl32(acc_ff[1], 7) +
                                   xxh_pkg::rotl32(acc_ff[2], 12) +
                                   xxh_pkg::rotl32(acc_ff[3], 18))
                                : xxh_pkg::PRIME5) + total_ff;
               if (pcnt_ff != 2'd0) state_ff <= S_W_MUL1;
               else if (nb_ff != 3'd0 && nb_ff != 3'd4) state_ff <= S_B_MUL1;
               else state_ff <= S_AV1;
            end
            S_W_MUL1: begin
               tmp_ff   <= xxh_pkg::rotl32(h_ff + prod, 17);
               state_ff <= S_W_MUL2;
            end
            S_W_MUL2: begin
               h_ff   <= prod;
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff + 2'd1 != pcnt_ff) state_ff <= S_W_MUL1;
               else if (nb_ff != 3'd0 && nb_ff != 3'd4) state_ff <= S_B_MUL1;
               else state_ff <= S_AV1;
            end
            S_B_MUL1: begin
               tmp_ff   <= xxh_pkg::rotl32(h_ff + prod, 11);
               state_ff <= S_B_MUL2;
            end
            S_B_MUL2: begin
               h_ff    <= prod;
               data_ff <= data_ff >> 8;
               nb_ff   <= nb_ff - 3'd1;
               state_ff <= (nb_ff == 3'd1) ? S_AV1 : S_B_MUL1;
            end
            S_AV1: begin
               h_ff     <= prod;
               state_ff <= S_AV2;
            end
            S_AV2: begin
               h_ff     <= prod;
               state_ff <= S_AV3;
            end
            S_AV3: begin
               if (!rv_ff || rsp.ready) begin
                  hash_ff   <= h_ff ^ (h_ff >> 16);
                  rv_ff     <= 1'b1;
                  acc_ff[0] <= xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
                  acc_ff[1] <= xxh_pkg::PRIME2;
                  acc_ff[2] <= 32'd0;
                  acc_ff[3] <= 32'd0 - xxh_pkg::PRIME1;
                  pcnt_ff   <= 2'd0;
                  total_ff  <= 32'd0;
                  seen_ff   <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_q_ff <= 1'b0;
      end else if (q_pop) begin
         last_q_ff <= q_data.last;
      end
   end
endmodule
`default_nettype wire

### rtl/xxhash32_stream.sv
// Top level: streaming xxHash32 (seed zero) over little-endian 32-bit words.
// Throughput: one word per cycle while buffering; the fourth word of a stripe is held while
// the shared multiplier updates each lane in turn (S_RND_MUL1, then S_RND_MUL2).
// A last request, once popped, runs merge, held-word and tail-byte rounds, then avalanche,
// preceded by a lane update if it ends a stripe; when idle, pop is the cycle after acceptance.
// Synchronous active-high reset clears accumulators, counts and both channels.
`default_nettype none
module xxhash32_stream (
   input wire logic clock,
   input wire logic reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_data,
   input  wire logic [2:0]  req_valid_bytes,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_hash
);
   xxh_req_if req ();
   xxh_rsp_if rsp ();
   xxh_pkg::entry_type q_data;
   logic q_valid, q_pop;

   assign req.valid       = req_valid;
   assign req.data        = req_data;
   assign req.valid_bytes = req_valid_bytes;
   assign req.last        = req_last;
   assign req_ready       = req.ready;
   assign rsp_valid       = rsp.valid;
   assign rsp_hash        = rsp.hash;
   assign rsp.ready       = rsp_ready;

   xxh_front u_front (.clock, .reset, .req(req.sink), .q_data, .q_valid, .q_pop);
   xxh_back  u_back  (.clock, .reset, .q_data, .q_valid, .q_pop, .rsp(rsp.source));
endmodule
`default_nettype wire

### rtl/xxh_checker.sv
// Checker: port-level properties of the xxHash32 stream block.
`default_nettype none
module xxh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_hash
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash))
      else $error("response dropped while stalled");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_ready, rsp_valid}) && (!rsp_valid || !$isunknown(rsp_hash)))
      else $error("handshake or hash unknown");
endmodule

bind xxhash32_stream xxh_checker u_chk (.*);
`default_nettype wire
